// ===== hw/rtl/bitmap_block_allocator_core_macros.svh =====
// assertion helpers shared by the checkers of this block
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// property sampled on the clock, ignored while reset is asserted
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property sampled on the clock, also checked during reset
`define BBA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/bba_pkg.sv =====
package bba_pkg;

  // default map size in blocks
  localparam int unsigned HeapBlocksDef = 64;

  // fixed field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned CountW   = 7;
  localparam int unsigned StartW   = 6;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  // request kinds
  typedef enum logic [OpW-1:0] {
    OpAlloc   = 2'd0,
    OpFree    = 2'd1,
    OpFreeAll = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StDone    = 2'd0,
    StInvalid = 2'd1,
    StNoSpace = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SCheck,
    SMark,
    SResp
  } state_e;

  // control from the sequencer to the run scanner
  typedef struct packed {
    logic clear;
    logic step;
    logic worst;
  } scan_ctrl_t;

endpackage

// ===== hw/rtl/bitmap_block_allocator_core.sv =====
// Bitmap block allocator: occupancy map of HeapBlocks fixed-size blocks.
// Requests enter on the s_axis channel: tuser carries the op (allocate run,
// free range, free all), tdata carries count and start_req. One result word
// per request leaves on m_axis: status and the allocated start block.
// The strategy register (first fit or worst fit) is written through cfg_we_i /
// cfg_wdata_i; the user writes it only while no request is in flight (not enforced).
// The map sits in a rotating shift register; one bit passes the run scanner
// or the mark logic per cycle during each pass over the map. Steps from
// accept to result valid:
//   allocate:            scan pass, check, mark pass
//   allocate, no space:  scan pass, check
//   free range:          mark pass
//   free all, invalid:   straight to the result
// One request is worked on at a time; s_axis_tready is high only while the
// sequencer is idle, which it is once the previous result is registered.
// A finished word waits in the output register; if the receiver stalls, the
// next request may still be accepted and worked on, and its result is held
// until the previous word is taken.
// Reset frees every block, selects first fit and empties the output.
module bitmap_block_allocator_core import bba_pkg::*; #(
  parameter int unsigned HeapBlocks = HeapBlocksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // count[6:0], start_req[12:7], zero pad
  input  logic [OpW-1:0]      s_axis_tuser,   // op[1:0]
  // result channel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // status[1:0], alloc_start[7:2]
  // strategy register
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(HeapBlocks + 1) + 1;
  localparam int unsigned ExtW = (CntW > 8) ? CntW : 8;
  localparam logic [ExtW-1:0] HeapX   = ExtW'(HeapBlocks);
  localparam logic [ExtW-1:0] LastPos = ExtW'(HeapBlocks - 1);

  // request fields
  op_e               req_op;
  logic [CountW-1:0] req_count;
  logic [StartW-1:0] req_start;
  logic [ExtW-1:0]   count_x, start_x, free_end;
  logic              alloc_ok, free_ok;

  assign req_op    = op_e'(s_axis_tuser);
  assign req_count = s_axis_tdata[CountW-1:0];
  assign req_start = s_axis_tdata[CountW+StartW-1:CountW];
  assign count_x   = ExtW'(req_count);
  assign start_x   = ExtW'(req_start);
  assign free_end  = start_x + count_x;
  assign alloc_ok  = (req_count != '0) && (count_x <= HeapX);
  assign free_ok   = (req_count != '0) && (start_x < HeapX) && (free_end <= HeapX);

  state_e                state_q, state_d;
  logic [HeapBlocks-1:0] map_q;
  logic [ExtW-1:0]       pos_q;
  logic [ExtW-1:0]       len_q;
  logic [ExtW-1:0]       base_q;
  logic                  set_q;
  status_e               status_q;
  logic [StartW-1:0]     res_start_q;
  logic                  strategy_q;
  logic                  out_valid_q;
  logic [OutDataW-1:0]   out_data_q;

  logic       accept;
  logic       out_free;
  logic       last_pos;
  logic       in_range;
  logic       mark_bit;
  scan_ctrl_t scan_ctrl;
  logic       fit;
  logic [ExtW-1:0] fit_start;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign last_pos = (pos_q == LastPos);
  assign in_range = (pos_q >= base_q) && (pos_q < (base_q + len_q));
  assign mark_bit = in_range ? set_q : map_q[0];

  // run scanner
  assign scan_ctrl.clear = accept;
  assign scan_ctrl.step  = (state_q == SScan);
  assign scan_ctrl.worst = strategy_q;

  bba_run_scan #(
    .HeapBlocks (HeapBlocks)
  ) u_run_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .bit_free_i (!map_q[0]),
    .pos_i      (pos_q),
    .len_i      (len_q),
    .fit_o      (fit),
    .start_o    (fit_start)
  );

  // next state and handshake
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      SIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          priority if (req_op == OpAlloc && alloc_ok) begin
            state_d = SScan;
          end else if (req_op == OpFree && free_ok) begin
            state_d = SMark;
          end else begin
            state_d = SResp;
          end
        end
      end
      SScan: begin
        if (last_pos) begin
          state_d = SCheck;
        end
      end
      SCheck: begin
        state_d = fit ? SMark : SResp;
      end
      SMark: begin
        if (last_pos) begin
          state_d = SResp;
        end
      end
      SResp: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control registers and occupancy map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      map_q       <= '0;
      pos_q       <= '0;
      strategy_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        strategy_q <= cfg_wdata_i;
      end
      // rotate the map one bit per cycle during a pass
      unique case (state_q)
        SIdle: begin
          pos_q <= '0;
          if (accept && req_op == OpFreeAll) begin
            map_q <= '0;
          end
        end
        SScan: begin
          map_q <= {map_q[0], map_q[HeapBlocks-1:1]};
          pos_q <= last_pos ? '0 : pos_q + ExtW'(1);
        end
        SMark: begin
          map_q <= {mark_bit, map_q[HeapBlocks-1:1]};
          pos_q <= last_pos ? '0 : pos_q + ExtW'(1);
        end
        default: begin
          pos_q <= '0;
        end
      endcase
      // output word register
      if (state_q == SResp && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request payload and pending result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_q       <= count_x;
      base_q      <= start_x;
      set_q       <= 1'b0;
      res_start_q <= '0;
      unique case (req_op)
        OpAlloc:   status_q <= alloc_ok ? StDone : StInvalid;
        OpFree:    status_q <= free_ok ? StDone : StInvalid;
        OpFreeAll: status_q <= StDone;
        default:   status_q <= StInvalid;
      endcase
    end else if (state_q == SCheck) begin
      if (fit) begin
        base_q      <= fit_start;
        set_q       <= 1'b1;
        res_start_q <= fit_start[StartW-1:0];
      end else begin
        status_q <= StNoSpace;
      end
    end
    if (state_q == SResp && out_free) begin
      out_data_q <= {res_start_q, status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/bba_run_scan.sv =====
module bba_run_scan import bba_pkg::*; #(
  parameter  int unsigned HeapBlocks = HeapBlocksDef,
  localparam int unsigned CntW       = $clog2(HeapBlocks + 1) + 1,
  localparam int unsigned ExtW       = (CntW > 8) ? CntW : 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scan_ctrl_t           ctrl_i,
  input  logic                 bit_free_i,
  input  logic [ExtW-1:0]      pos_i,
  input  logic [ExtW-1:0]      len_i,
  output logic                 fit_o,
  output logic [ExtW-1:0]      start_o
);

  logic [ExtW-1:0] run_q, run_d;
  logic [ExtW-1:0] run_start_q, run_start_d;
  logic [ExtW-1:0] best_len_q, best_len_d;
  logic [ExtW-1:0] best_start_q, best_start_d;
  logic            found_q, found_d;
  logic [ExtW-1:0] run_inc;
  logic [ExtW-1:0] cur_start;

  // one map bit per step: track current free run and the chosen one
  always_comb begin
    run_inc      = run_q + ExtW'(1);
    cur_start    = (run_q == '0) ? pos_i : run_start_q;
    run_d        = run_q;
    run_start_d  = run_start_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    found_d      = found_q;
    if (ctrl_i.clear) begin
      run_d      = '0;
      best_len_d = '0;
      found_d    = 1'b0;
    end else if (ctrl_i.step) begin
      if (bit_free_i) begin
        run_d       = run_inc;
        run_start_d = cur_start;
        if (ctrl_i.worst) begin
          // strictly longer keeps the earliest run on a tie
          if (run_inc > best_len_q) begin
            best_len_d   = run_inc;
            best_start_d = cur_start;
          end
        end else if (!found_q && run_inc == len_i) begin
          found_d      = 1'b1;
          best_start_d = cur_start;
        end
      end else begin
        run_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= '0;
      best_len_q <= '0;
      found_q    <= 1'b0;
    end else begin
      run_q      <= run_d;
      best_len_q <= best_len_d;
      found_q    <= found_d;
    end
  end

  // run start positions are payload
  always_ff @(posedge clk_i) begin
    run_start_q  <= run_start_d;
    best_start_q <= best_start_d;
  end

  assign fit_o   = ctrl_i.worst ? ((best_len_q >= len_i) && (best_len_q != '0)) : found_q;
  assign start_o = best_start_q;

endmodule

// ===== hw/rtl/bba_checker.sv =====
`include "bitmap_block_allocator_core_macros.svh"

module bba_checker import bba_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // the output word stays empty while reset is held
  `BBA_ASSERT_RST(a_no_word_in_reset, !rst_ni |-> !m_axis_tvalid, "word valid during reset")

  // only defined status codes leave the block
  `BBA_ASSERT(a_status_code, m_axis_tvalid |-> (m_axis_tdata[1:0] <= StNoSpace), "undefined status")

  // a failed request (status other than done) reports start zero
  `BBA_ASSERT(a_start_zero,
    (m_axis_tvalid && m_axis_tdata[1:0] != StDone && m_axis_tdata[1:0] <= StNoSpace) |->
    (m_axis_tdata[7:2] == 6'd0), "start not zero on failure")

  // one request at a time: ready drops after an accept
  `BBA_ASSERT(a_one_in_flight, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
    "second word taken while busy")

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned RandomItems = 1880;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned HoldAtWord  = 300;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned DrainCycles = 2 * HeapBlocksDef + 8;

  // op code the block does not define
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  // strategy register values
  localparam bit FirstFit = 1'b0;
  localparam bit WorstFit = 1'b1;

  typedef struct {
    status_e           status;
    logic [StartW-1:0] first;
  } alloc_result_t;

  typedef struct {
    logic [StartW-1:0] first;
    logic [CountW-1:0] len;
  } block_run_t;

  // occupancy map model and queue of awaited result words
  class alloc_scoreboard;
    logic [HeapBlocksDef-1:0] occupied;
    bit                       widest_mode;
    alloc_result_t            awaited[$];
    int unsigned              mismatches;

    function new();
      occupied    = '0;
      widest_mode = FirstFit;
      mismatches  = 0;
    endfunction

    // lowest start of a free run of len blocks, -1 if none
    function int first_fit_start(int len);
      int run;
      run = 0;
      for (int b = 0; b < HeapBlocksDef; b++) begin
        if (!occupied[b]) begin
          run++;
          if (run == len) return b + 1 - len;
        end else begin
          run = 0;
        end
      end
      return -1;
    endfunction

    // start of the widest free run (earliest on a tie) if it holds len
    function int widest_run_start(int len);
      int best_len, best_first, run, run_first;
      best_len   = 0;
      best_first = 0;
      run        = 0;
      run_first  = 0;
      for (int b = 0; b < HeapBlocksDef; b++) begin
        if (!occupied[b]) begin
          if (run == 0) run_first = b;
          run++;
          if (run > best_len) begin
            best_len   = run;
            best_first = run_first;
          end
        end else begin
          run = 0;
        end
      end
      return (best_len >= len && best_len > 0) ? best_first : -1;
    endfunction

    // apply an accepted request to the map and queue its result
    function alloc_result_t note_request(logic [OpW-1:0] op, logic [CountW-1:0] cnt,
                                         logic [StartW-1:0] st);
      alloc_result_t r;
      int            s;
      r.status = StInvalid;
      r.first  = '0;
      case (op)
        OpAlloc: begin
          if (cnt != 0 && cnt <= HeapBlocksDef) begin
            s = widest_mode ? widest_run_start(cnt) : first_fit_start(cnt);
            if (s >= 0) begin
              for (int b = s; b < s + int'(cnt) && b < HeapBlocksDef; b++) occupied[b] = 1'b1;
              r.status = StDone;
              r.first  = s[StartW-1:0];
            end else begin
              r.status = StNoSpace;
            end
          end
        end
        OpFree: begin
          if (cnt != 0 && int'(st) + int'(cnt) <= HeapBlocksDef) begin
            for (int b = st; b < int'(st) + int'(cnt); b++) occupied[b] = 1'b0;
            r.status = StDone;
          end
        end
        OpFreeAll: begin
          occupied = '0;
          r.status = StDone;
        end
        default: r.status = StInvalid;
      endcase
      awaited.push_back(r);
      return r;
    endfunction

    // compare one result word with the oldest awaited result
    function void check_word(logic [OutDataW-1:0] word);
      alloc_result_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, word);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (word[1:0] != exp.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, exp.status,
                 word[1:0]);
        mismatches++;
      end
      if (word[7:2] != exp.first) begin
        $display("%0t: alloc_start mismatch, expected %0d, actual %0d", $time, exp.first,
                 word[7:2]);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [OpW-1:0]      s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_wdata_i   = 1'b0;

  alloc_scoreboard sb = new();
  block_run_t      live_runs[$];
  bit              steady = 1'b0;
  int unsigned     cycles = 0;

  bitmap_block_allocator_core #(
    .HeapBlocks(HeapBlocksDef)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one request word after a random gap (none when steady), return its predicted result
  task automatic issue(input logic [OpW-1:0] op, input logic [CountW-1:0] cnt,
                       input logic [StartW-1:0] st, output alloc_result_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, st, cnt};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    r = sb.note_request(op, cnt, st);
  endtask

  // write the strategy register once the block has gone idle
  task automatic set_strategy(input bit value);
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    sb.widest_mode = value;
  endtask

  // mostly well-formed alloc and free traffic, some noise
  task automatic random_item();
    int                pick;
    int                idx;
    logic [CountW-1:0] cnt;
    alloc_result_t     r;
    block_run_t        run;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      idx = $urandom_range(0, 19);
      if (idx < 14) cnt = $urandom_range(1, 8);
      else if (idx < 19) cnt = $urandom_range(9, 24);
      else cnt = $urandom_range(25, 64);
      issue(OpAlloc, cnt, 6'($urandom), r);
      if (r.status == StDone) live_runs.push_back('{r.first, cnt});
    end else if (pick < 80) begin
      if (live_runs.size() > 0) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        issue(OpFree, run.len, run.first, r);
      end else begin
        issue(OpFree, 7'($urandom_range(1, 64)), 6'($urandom), r);
      end
    end else if (pick < 84) begin
      issue(OpFreeAll, 7'($urandom), 6'($urandom), r);
      live_runs.delete();
    end else begin
      issue(2'($urandom), 7'($urandom), 6'($urandom), r);
    end
  endtask

  // result sink with random stalls and one long hold-off
  initial begin
    int          stall;
    int unsigned words;
    words = 0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (words == HoldAtWord) stall = HoldCycles;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata);
      words++;
    end
  end

  // reset, directed cases, random phases, drain
  initial begin
    alloc_result_t r;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first fit: count limits, full map, range checks, unused op
    issue(OpAlloc, 7'd0, 6'd0, r);
    issue(OpAlloc, 7'd65, 6'd0, r);
    issue(OpAlloc, 7'd127, 6'd63, r);
    issue(OpAlloc, 7'd64, 6'd0, r);
    issue(OpAlloc, 7'd1, 6'd0, r);
    issue(OpFree, 7'd0, 6'd0, r);
    issue(OpFree, 7'd2, 6'd63, r);
    issue(OpFree, 7'd1, 6'd63, r);
    issue(OpAlloc, 7'd1, 6'd0, r);
    issue(OpFree, 7'd64, 6'd0, r);
    issue(OpFree, 7'd5, 6'd10, r);
    issue(OpAlloc, 7'd10, 6'd0, r);
    issue(OpAlloc, 7'd20, 6'd0, r);
    issue(OpFree, 7'd4, 6'd3, r);
    issue(OpUnused, 7'd5, 6'd7, r);
    issue(OpFreeAll, 7'd127, 6'd63, r);

    // worst fit: widest run, too short, earliest leftover
    set_strategy(WorstFit);
    issue(OpAlloc, 7'd5, 6'd0, r);
    issue(OpAlloc, 7'd10, 6'd0, r);
    issue(OpFree, 7'd5, 6'd0, r);
    issue(OpAlloc, 7'd50, 6'd0, r);
    issue(OpAlloc, 7'd49, 6'd0, r);
    issue(OpAlloc, 7'd3, 6'd0, r);
    issue(OpAlloc, 7'd3, 6'd0, r);
    issue(OpFreeAll, 7'd0, 6'd0, r);

    // random phases, alternating strategy, some without idling
    for (int p = 0; p < PhaseCount; p++) begin
      set_strategy((p % 2 == 0) ? FirstFit : WorstFit);
      steady = (p % 3 == 2);
      for (int i = 0; i < RandomItems / PhaseCount; i++) random_item();
    end
    steady = 1'b0;

    // drain
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
